// ----- rtl/core/oahi_pkg.sv -----
`timescale 1ns / 1ps
package oahi_pkg;
    localparam int SLOTS = 64;
    localparam int KEY_W = 48;
    localparam int NAME_W = 64;
    localparam int LIM_W = 7;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_QUAD = 2'd1;
    localparam logic [1:0] MODE_DOUBLE = 2'd2;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_SIZE = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic probe_first;
        logic probe_next;
        logic write_slot;
        logic finish;
    } oahi_cmd_t;

    typedef struct packed {
        logic is_read;
        logic mod_done;
        logic slot_free;
        logic limit_hit;
        logic idx_ready;
    } oahi_stat_t;
endpackage

// ----- rtl/core/open_address_hash_insert.sv -----
`timescale 1ns / 1ps
// Open-addressing hash insert engine. A transaction is taken when start is high
// and busy is low; its one result appears for a single cycle with done high and
// cannot be held off. A read goes from its load straight to reporting. An
// insert first reduces the key mod table_size bit-serially, one key bit per
// step, and then forms the home slot. The probe index of each slot checked is
// brought below table_size by compare-and-subtract steps; a step removes eight
// times table_size while it can, so far quadratic probes take longest. A free
// slot is then written and reported; if none is found within the probe limit,
// the insert reports full.
module open_address_hash_insert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        opcode,
    input  logic [47:0] key,
    input  logic [63:0] name_tag,
    input  logic [5:0]  read_slot,
    output logic        done,
    output logic [1:0]  status,
    output logic [5:0]  slot_index,
    output logic        occupied,
    output logic [47:0] key_out,
    output logic [63:0] name_out,
    output logic [6:0]  probe_count
);
    import oahi_pkg::*;

    logic [1:0] mode_reg;
    logic [6:0] size_reg;
    logic [6:0] limit_reg;
    oahi_cmd_t  cmd;
    oahi_stat_t stat;
    logic       go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 2'd0;
            size_reg <= 7'd5;
            limit_reg <= 7'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg <= cfg_data[1:0];
                CFG_SIZE:  size_reg <= cfg_data;
                CFG_LIMIT: limit_reg <= cfg_data;
                default:   mode_reg <= mode_reg;
            endcase
        end
    end

    assign go = start && !busy;

    oahi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (go),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    oahi_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_mode    (mode_reg),
        .cfg_size    (size_reg),
        .cfg_limit   (limit_reg),
        .opcode      (opcode),
        .key         (key),
        .name_tag    (name_tag),
        .read_slot   (read_slot),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index),
        .occupied    (occupied),
        .key_out     (key_out),
        .name_out    (name_out),
        .probe_count (probe_count)
    );
endmodule

// ----- rtl/core/oahi_ctrl.sv -----
`timescale 1ns / 1ps
module oahi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  oahi_pkg::oahi_stat_t stat,
    output oahi_pkg::oahi_cmd_t  cmd,
    output logic                busy
);
    import oahi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_IDX   = 6'b000100,
        S_CHECK = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (stat.is_read)
                begin
                    state_next = S_DONE;
                end
                else if (stat.mod_done)
                begin
                    cmd.probe_first = 1'b1;
                    state_next = S_IDX;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_IDX:
            begin
                if (stat.idx_ready)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (stat.slot_free)
                begin
                    state_next = S_WRITE;
                end
                else if (stat.limit_hit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next = S_IDX;
                end
            end
            S_WRITE:
            begin
                cmd.write_slot = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

// ----- rtl/core/oahi_dp.sv -----
`timescale 1ns / 1ps
module oahi_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  oahi_pkg::oahi_cmd_t       cmd,
    output oahi_pkg::oahi_stat_t      stat,
    input  logic [1:0]                cfg_mode,
    input  logic [6:0]                cfg_size,
    input  logic [6:0]                cfg_limit,
    input  logic                      opcode,
    input  logic [47:0]               key,
    input  logic [63:0]               name_tag,
    input  logic [5:0]                read_slot,
    output logic                      done,
    output logic [1:0]                status,
    output logic [5:0]                slot_index,
    output logic                      occupied,
    output logic [47:0]               key_out,
    output logic [63:0]               name_out,
    output logic [6:0]                probe_count
);
    import oahi_pkg::*;

    localparam int IW = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int SW = $clog2(SLOTS + 1);
    // Sequence values are at most 127*127 plus home, and 127*7 plus home.
    localparam int OW = 15;

    logic [SLOTS-1:0]  used_reg;
    logic [KEY_W-1:0]  mem_key [SLOTS];
    logic [NAME_W-1:0] mem_name [SLOTS];

    logic              op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [NAME_W-1:0] name_reg;
    logic [5:0]        rslot_reg;
    logic [SW-1:0]     size_reg;
    logic [KEY_W-1:0]  rem_reg;
    logic [5:0]        bit_reg;
    logic [2:0]        m7_reg;
    logic [IW-1:0]     home_reg;
    logic [IW-1:0]     idx_reg;
    logic [OW-1:0]     red_reg;
    logic [LIM_W-1:0]  f_reg;
    logic [LIM_W-1:0]  lim_reg;
    logic              full_reg;
    logic              done_reg;
    logic [KEY_W-1:0]  rk_reg;
    logic [NAME_W-1:0] rn_reg;
    logic              ru_reg;

    logic [SW-1:0]     eff_size;
    logic [KEY_W:0]    trial;
    logic [2:0]        m7_next;
    logic [OW-1:0]     off_next;
    logic [OW-1:0]     fsq;
    logic [LIM_W:0]    f1;
    logic [3:0]        step7;

    always_comb
    begin
        if (cfg_size < 7'd2)
        begin
            eff_size = SW'(2);
        end
        else if ({{(32-7){1'b0}}, cfg_size} > 32'(SLOTS))
        begin
            eff_size = SW'(SLOTS);
        end
        else
        begin
            eff_size = SW'(cfg_size);
        end
    end

    // Restoring remainder, one key bit per cycle, also tracks key mod 7.
    assign trial = {rem_reg, key_reg[bit_reg]};
    always_comb
    begin
        logic [3:0] t;
        t = {m7_reg, key_reg[bit_reg]};
        m7_next = (t >= 4'd7) ? 3'(t - 4'd7) : t[2:0];
    end

    assign f1 = {1'b0, f_reg} + 8'd1;
    assign fsq = OW'(f1) * OW'(f1);
    assign step7 = 4'd7 - {1'b0, m7_reg};

    always_comb
    begin
        unique case (cfg_mode)
            MODE_QUAD:   off_next = fsq;
            MODE_DOUBLE: off_next = OW'(f1) * OW'(step7);
            default:     off_next = OW'(f1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.write_slot)
            begin
                used_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_slot)
        begin
            mem_key[idx_reg] <= key_reg;
            mem_name[idx_reg] <= name_reg;
        end
        rk_reg <= mem_key[rslot_reg[IW-1:0]];
        rn_reg <= mem_name[rslot_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            key_reg <= key;
            name_reg <= name_tag;
            rslot_reg <= read_slot;
            size_reg <= eff_size;
            lim_reg <= cfg_limit;
            rem_reg <= '0;
            m7_reg <= '0;
            bit_reg <= 6'(KEY_W - 1);
            f_reg <= '0;
            full_reg <= 1'b1;
        end
        else if (cmd.mod_step && !stat.mod_done)
        begin
            rem_reg <= (trial >= (KEY_W+1)'(size_reg)) ?
                KEY_W'(trial - (KEY_W+1)'(size_reg)) : KEY_W'(trial);
            m7_reg <= m7_next;
            bit_reg <= bit_reg - 6'd1;
        end
        else if (cmd.mod_step)
        begin
            if (red_reg >= OW'(size_reg))
            begin
                red_reg <= red_reg - OW'(size_reg) * ((red_reg >= OW'(size_reg) * 8)
                    ? OW'(8) : OW'(1));
            end
        end
        if (cmd.probe_first)
        begin
            home_reg <= IW'(rem_reg);
            red_reg <= OW'(rem_reg);
        end
        if (cmd.probe_next)
        begin
            f_reg <= f1[LIM_W-1:0];
            red_reg <= OW'(home_reg) + off_next;
        end
        if (stat.idx_ready && !cmd.mod_step)
        begin
            idx_reg <= IW'(red_reg);
        end
        if (cmd.write_slot)
        begin
            full_reg <= 1'b0;
        end
        ru_reg <= (32'(rslot_reg) < 32'(SLOTS)) && used_reg[rslot_reg[IW-1:0]];
    end

    // bit_reg wraps to all ones once the last key bit has been taken.
    assign stat.is_read = op_reg;
    assign stat.mod_done = (bit_reg == 6'h3f);
    assign stat.idx_ready = (red_reg < OW'(size_reg));
    assign stat.slot_free = !used_reg[IW'(red_reg)];
    assign stat.limit_hit = (f_reg >= lim_reg);

    assign done = done_reg;

    always_comb
    begin
        status = ST_INSERTED;
        slot_index = 6'(idx_reg);
        occupied = 1'b1;
        key_out = key_reg;
        name_out = name_reg;
        probe_count = f_reg;
        if (op_reg)
        begin
            status = ST_READ;
            slot_index = rslot_reg;
            occupied = ru_reg;
            key_out = ru_reg ? rk_reg : '0;
            name_out = ru_reg ? rn_reg : '0;
            probe_count = '0;
        end
        else if (full_reg)
        begin
            status = ST_FULL;
            slot_index = 6'(home_reg);
            occupied = 1'b0;
            key_out = '0;
            name_out = '0;
            probe_count = lim_reg;
        end
    end
endmodule

// ----- dv/open_address_hash_insert_tb.sv -----
`timescale 1ns / 1ps
module open_address_hash_insert_tb;
    import oahi_pkg::*;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ = 1'b1;
    localparam int CYCLE_LIMIT = 5000000;

    class hash_scoreboard;
        typedef struct packed {
            logic [1:0]  status;
            logic [5:0]  slot;
            logic        occ;
            logic [47:0] key;
            logic [63:0] name;
            logic [6:0]  probes;
        } slot_result_t;

        slot_result_t expected_q[$];
        bit          used [64];
        logic [47:0] keys [64];
        logic [63:0] names [64];
        logic [1:0]  mode;
        logic [6:0]  size;
        logic [6:0]  limit;
        int          errors;

        function new();
            mode = MODE_LINEAR;
            size = 7'd5;
            limit = 7'd100;
            errors = 0;
            foreach (used[i]) used[i] = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [6:0] value);
            if (idx == CFG_MODE) mode = value[1:0];
            else if (idx == CFG_SIZE) size = value;
            else if (idx == CFG_LIMIT) limit = value;
        endfunction

        function void note_item(logic op, logic [47:0] k, logic [63:0] n, logic [5:0] rslot);
            slot_result_t r;
            longint unsigned sz, home, idx, f, off, key64;
            bit found;
            if (op == OP_READ)
            begin
                r.status = ST_READ;
                r.slot = rslot;
                r.occ = used[rslot];
                r.key = used[rslot] ? keys[rslot] : '0;
                r.name = used[rslot] ? names[rslot] : '0;
                r.probes = '0;
            end
            else
            begin
                key64 = k;
                sz = (size < 2) ? 2 : ((size > 64) ? 64 : size);
                home = key64 % sz;
                idx = home;
                f = 0;
                found = !used[idx];
                while (!found && f < limit)
                begin
                    f++;
                    if (mode == MODE_QUAD) off = f * f;
                    else if (mode == MODE_DOUBLE) off = f * (7 - key64 % 7);
                    else off = f;
                    idx = (home + off) % sz;
                    found = !used[idx];
                end
                if (found)
                begin
                    used[idx] = 1'b1;
                    keys[idx] = k;
                    names[idx] = n;
                    r.status = ST_INSERTED;
                    r.slot = idx[5:0];
                    r.occ = 1'b1;
                    r.key = k;
                    r.name = n;
                    r.probes = f[6:0];
                end
                else
                begin
                    r.status = ST_FULL;
                    r.slot = home[5:0];
                    r.occ = 1'b0;
                    r.key = '0;
                    r.name = '0;
                    r.probes = limit;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(slot_result_t got);
            slot_result_t exp;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("Unexpected result: status %0d slot %0d",
                                           got.status, got.slot);
                return;
            end
            exp = expected_q.pop_front();
            if (got !== exp)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("Mismatch: expected st %0d slot %0d occ %0d key %h name %h pc %0d",
                             exp.status, exp.slot, exp.occ, exp.key, exp.name, exp.probes);
                    $display("          actual   st %0d slot %0d occ %0d key %h name %h pc %0d",
                             got.status, got.slot, got.occ, got.key, got.name, got.probes);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        opcode;
    logic [47:0] key;
    logic [63:0] name_tag;
    logic [5:0]  read_slot;
    logic        done;
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic        occupied;
    logic [47:0] key_out;
    logic [63:0] name_out;
    logic [6:0]  probe_count;

    hash_scoreboard sb = new();
    int cycles = 0;
    int burst_left = 0;

    open_address_hash_insert dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        hash_scoreboard::slot_result_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("open_address_hash_insert_tb failed");
            $finish;
        end
        if (rst_n && start && !busy) sb.note_item(opcode, key, name_tag, read_slot);
        if (rst_n && done)
        begin
            got.status = status;
            got.slot = slot_index;
            got.occ = occupied;
            got.key = key_out;
            got.name = name_out;
            got.probes = probe_count;
            sb.check_result(got);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [6:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic send(logic op, logic [47:0] k, logic [63:0] n, logic [5:0] rslot);
        start <= 1'b1;
        opcode <= op;
        key <= k;
        name_tag <= n;
        read_slot <= rslot;
        do @(posedge clk); while (busy);
        if (burst_left > 0) burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_item();
        logic [47:0] k;
        case ($urandom_range(0, 3))
            0: k = 48'({$urandom, $urandom});
            1: k = 48'($urandom_range(0, 300));
            2: k = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 50));
            default: k = 48'({$urandom, $urandom} >> $urandom_range(0, 47));
        endcase
        if ($urandom_range(0, 9) < 6) send(OP_INSERT, k, {$urandom, $urandom}, 6'($urandom));
        else send(OP_READ, k, {$urandom, $urandom}, 6'($urandom_range(0, 63)));
    endtask

    initial
    begin
        logic [6:0] sizes [12] = '{7'd2, 7'd0, 7'd1, 7'd7, 7'd3, 7'd12,
                                   7'd20, 7'd33, 7'd127, 7'd45, 7'd64, 7'd64};
        logic [6:0] limits [12] = '{7'd0, 7'd1, 7'd127, 7'd100, 7'd5, 7'd10,
                                    7'd3, 7'd8, 7'd2, 7'd12, 7'd6, 7'd4};
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        opcode = OP_INSERT;
        key = '0;
        name_tag = '0;
        read_slot = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_INSERT, 48'h0, 64'h0, 6'd0);
        send(OP_INSERT, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send(OP_INSERT, 48'h5, 64'h4E41_4D45_5F30_3031, 6'd0);
        send(OP_INSERT, 48'h5, 64'h4E41_4D45_5F30_3032, 6'd0);
        send(OP_INSERT, 48'hA, 64'h1234_5678_9ABC_DEF0, 6'd0);
        send(OP_INSERT, 48'h7, 64'h0F0F_0F0F_0F0F_0F0F, 6'd0);
        send(OP_READ, 48'h0, 64'h0, 6'd0);
        send(OP_READ, 48'h0, 64'h0, 6'd4);
        send(OP_READ, 48'h0, 64'h0, 6'd63);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            write_reg(CFG_MODE, 7'($urandom_range(0, 3)));
            write_reg(CFG_SIZE, sizes[p]);
            write_reg(CFG_LIMIT, limits[p]);
            if (p == 0) write_reg(CFG_MODE, 7'(MODE_QUAD));
            if (p == 1) write_reg(CFG_MODE, 7'(MODE_DOUBLE));
            if (p == 2) write_reg(CFG_MODE, 7'd3);
            repeat (85) random_item();
            drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("open_address_hash_insert_tb passed");
        else
            $display("open_address_hash_insert_tb failed");
        $finish;
    end
endmodule

// ----- open_address_hash_insert.f -----
rtl/core/oahi_pkg.sv
rtl/core/oahi_ctrl.sv
rtl/core/oahi_dp.sv
rtl/core/open_address_hash_insert.sv
dv/open_address_hash_insert_tb.sv
